// ===== rtl/urlenc_pkg.sv =====
// shared types, constants and helpers for the url query percent encoder
package urlenc_pkg;

   // character codes
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT  = 8'h25;
   localparam logic [7:0] CHAR_LOWER_U  = 8'h75;
   localparam logic [7:0] CHAR_TERM     = 8'h00;
   localparam logic [7:0] CHAR_QUOTE    = 8'h22;
   localparam logic [7:0] CHAR_LT       = 8'h3C;
   localparam logic [7:0] CHAR_GT       = 8'h3E;
   localparam logic [7:0] CHAR_HASH     = 8'h23;
   localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE   = 8'h7D;
   localparam logic [7:0] CHAR_PIPE     = 8'h7C;
   localparam logic [7:0] CHAR_BSLASH   = 8'h5C;
   localparam logic [7:0] CHAR_CARET    = 8'h5E;
   localparam logic [7:0] CHAR_TILDE    = 8'h7E;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_BACKTICK = 8'h60;

   // status codes carried on the terminator
   localparam logic [1:0] STATUS_NONE  = 2'd0;
   localparam logic [1:0] STATUS_OK    = 2'd1;
   localparam logic [1:0] STATUS_TRUNC = 2'd2;

   // capacity after reset
   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // characters emitted per job kind
   localparam logic [2:0] LEN_ONE  = 3'd1;
   localparam logic [2:0] LEN_HEX2 = 3'd3;
   localparam logic [2:0] LEN_HEX4 = 3'd6;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
      logic [1:0] status;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      JOB_TERM,
      JOB_ONE,
      JOB_HEX2,
      JOB_HEX4
   } job_kind_type;

   // one classified item; data holds the byte for JOB_ONE, zero for JOB_TERM, the unit otherwise
   typedef struct packed {
      job_kind_type kind;
      logic [15:0]  data;
      logic [1:0]   status;
   } job_type;

   // uppercase hex digit
   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      logic [7:0] res;
      if (nibble > 4'd9) begin
         res = 8'h41 + {4'd0, nibble} - 8'd10;
      end else begin
         res = 8'h30 + {4'd0, nibble};
      end
      return res;
   endfunction

   // number of characters a job produces
   function automatic logic [2:0] job_len(input job_kind_type kind);
      logic [2:0] res;
      unique case (kind)
         JOB_HEX2: res = LEN_HEX2;
         JOB_HEX4: res = LEN_HEX4;
         default:  res = LEN_ONE;
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/urlenc_queue.sv =====
// small job fifo between the classifier and the serializer
module urlenc_queue
   import urlenc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   // handshake
   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/urlenc_front.sv =====
// input classifier: query tracking, room check and job generation
module urlenc_front
   import urlenc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   input  logic [15:0]     capacity,
   output logic            push_valid,
   input  logic            push_ready,
   output job_type         push_job
);

   logic        in_query_ff, in_query_in;
   logic [15:0] chars_ff, chars_in;
   logic        trunc_ff, trunc_in;

   logic        accept;
   logic [15:0] unit;
   logic        unsafe;
   job_type     job;
   logic [2:0]  len;
   logic [16:0] total;
   logic        fits;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign unit      = req_payload.code_unit;

   // unsafe set lookup
   always_comb begin
      case (unit[7:0]) inside
         CHAR_QUOTE, CHAR_LT, CHAR_GT, CHAR_HASH, CHAR_LBRACE, CHAR_RBRACE,
         CHAR_PIPE, CHAR_BSLASH, CHAR_CARET, CHAR_TILDE, CHAR_LBRACKET,
         CHAR_RBRACKET, CHAR_BACKTICK: unsafe = (unit[15:8] == 8'd0);
         default:                      unsafe = 1'b0;
      endcase
   end

   // classify the unit
   always_comb begin
      job.status = STATUS_NONE;
      job.data   = unit;
      if (!in_query_ff) begin
         job.kind = JOB_ONE;
      end else if (unit == {8'd0, CHAR_SPACE}) begin
         job.kind = JOB_ONE;
         job.data = {8'd0, CHAR_PLUS};
      end else if (unit[15:8] != 8'd0) begin
         job.kind = JOB_HEX4;
      end else if (unit[7] || unsafe) begin
         job.kind = JOB_HEX2;
      end else begin
         job.kind = JOB_ONE;
      end
   end

   // room check
   assign len   = job_len(job.kind);
   assign total = {1'b0, chars_ff} + {14'd0, len};
   assign fits  = (total <= {1'b0, capacity});

   // job push and state update
   always_comb begin
      in_query_in = in_query_ff;
      chars_in    = chars_ff;
      trunc_in    = trunc_ff;
      push_valid  = 1'b0;
      push_job    = job;
      if (accept) begin
         if (req_payload.end_of_string) begin
            push_valid      = 1'b1;
            push_job.kind   = JOB_TERM;
            push_job.data   = '0;
            push_job.status = trunc_ff ? STATUS_TRUNC : STATUS_OK;
            in_query_in     = 1'b0;
            chars_in        = '0;
            trunc_in        = 1'b0;
         end else if (!trunc_ff) begin
            if (fits) begin
               push_valid = 1'b1;
               chars_in   = total[15:0];
               if (unit == {8'd0, CHAR_QUESTION}) begin
                  in_query_in = 1'b1;
               end
            end else begin
               trunc_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_query_ff <= 1'b0;
         chars_ff    <= '0;
         trunc_ff    <= 1'b0;
      end else begin
         in_query_ff <= in_query_in;
         chars_ff    <= chars_in;
         trunc_ff    <= trunc_in;
      end
   end

endmodule

// ===== rtl/urlenc_back.sv =====
// job serializer: one output character per cycle into the output register unless the result side stalls
module urlenc_back
   import urlenc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  job_type         pop_job,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   job_type         cur_ff, cur_in;
   logic            cur_valid_ff, cur_valid_in;
   logic [2:0]      idx_ff, idx_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;

   logic            out_load;
   logic            is_last;
   logic [7:0]      ch;

   assign is_last   = (idx_ff == job_len(cur_ff.kind) - 3'd1);
   assign out_load  = cur_valid_ff && (!out_valid_ff || rsp_ready);
   assign pop_ready = !cur_valid_ff || (out_load && is_last);

   // character for the current position
   always_comb begin
      ch = CHAR_TERM;
      unique case (cur_ff.kind)
         JOB_TERM: ch = CHAR_TERM;
         JOB_ONE:  ch = cur_ff.data[7:0];
         JOB_HEX2: begin
            case (idx_ff)
               3'd0:    ch = CHAR_PERCENT;
               3'd1:    ch = hex_digit(cur_ff.data[7:4]);
               default: ch = hex_digit(cur_ff.data[3:0]);
            endcase
         end
         JOB_HEX4: begin
            case (idx_ff)
               3'd0:    ch = CHAR_PERCENT;
               3'd1:    ch = CHAR_LOWER_U;
               3'd2:    ch = hex_digit(cur_ff.data[15:12]);
               3'd3:    ch = hex_digit(cur_ff.data[11:8]);
               3'd4:    ch = hex_digit(cur_ff.data[7:4]);
               default: ch = hex_digit(cur_ff.data[3:0]);
            endcase
         end
         default:  ch = CHAR_TERM;
      endcase
   end

   // current job, position and output register
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in    = 1'b1;
         out_in.out_char = ch;
         out_in.last     = is_last;
         out_in.status   = cur_ff.status;
         idx_in          = idx_ff + 3'd1;
         if (is_last) begin
            cur_valid_in = 1'b0;
         end
      end
      if (pop_valid && pop_ready) begin
         cur_in       = pop_job;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// ===== rtl/url_query_percent_encoder_top.sv =====
// top level of the url query percent encoder
//
//   port group  direction  handshake          payload
//   req_        in         valid / ready      code_unit, end_of_string
//   rsp_        out        valid / ready      out_char, last, status
//   csr_        in         write enable only  csr_write_data (16 bits)
//
// an input unit yields 1, 3 or 6 characters; the serializer emits one character
// per cycle unless the result side stalls.
// units dropped after truncation queue nothing.
// a two-entry job queue lets the front accept while the back still serializes.
// reset is synchronous; capacity returns to 65535 and per-string state clears.
// the first character of a unit passes through the job queue and the current job register into the output register.
module url_query_percent_encoder_top
   import urlenc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_en,
   input  logic [15:0]     csr_write_data
);

   logic [15:0] capacity_ff;
   logic        push_valid, push_ready;
   job_type     push_job;
   logic        pop_valid, pop_ready;
   job_type     pop_job;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write_en) begin
         capacity_ff <= csr_write_data;
      end
   end

   urlenc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .capacity    (capacity_ff),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_job    (push_job)
   );

   urlenc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   urlenc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_job     (pop_job),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/url_encode_checker.sv =====
// checker for the url query percent encoder: predicts every character and compares results
module url_encode_checker
   import urlenc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_write_en,
   input  logic [15:0]     csr_write_data,
   output int              error_count,
   output int              pending_count,
   output int              checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // encoder state as seen from outside
   int  capacity = CAPACITY_RESET;
   int  emitted_count = 0;
   logic past_question = 1'b0;
   logic overflowed = 1'b0;

   rsp_payload_type expected_chars[$];
   int errors = 0;
   int checked = 0;

   // uppercase ascii hex digit
   function automatic logic [7:0] ascii_hex(input logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + {4'h0, v} : 8'h37 + {4'h0, v};
   endfunction

   function automatic logic is_unsafe(input logic [7:0] c);
      case (c)
         CHAR_QUOTE, CHAR_LT, CHAR_GT, CHAR_HASH, CHAR_LBRACE, CHAR_RBRACE, CHAR_PIPE,
         CHAR_BSLASH, CHAR_CARET, CHAR_TILDE, CHAR_LBRACKET, CHAR_RBRACKET,
         CHAR_BACKTICK: return 1'b1;
         default:       return 1'b0;
      endcase
   endfunction

   function automatic rsp_payload_type make_char(input logic [7:0] c, input logic fin,
                                                 input logic [1:0] st);
      rsp_payload_type r;
      r.out_char = c;
      r.last     = fin;
      r.status   = st;
      return r;
   endfunction

   // expected characters for one accepted input transfer
   task automatic predict_unit(input req_payload_type item);
      logic [7:0]  seq [0:5];
      logic [15:0] u;
      int n;
      u = item.code_unit;
      n = 1;
      if (item.end_of_string) begin
         expected_chars.push_back(make_char(CHAR_TERM, 1'b1,
                                            overflowed ? STATUS_TRUNC : STATUS_OK));
         past_question = 1'b0;
         emitted_count = 0;
         overflowed    = 1'b0;
      end else if (!overflowed) begin
         if (!past_question) begin
            seq[0] = u[7:0];
         end else if (u == {8'h00, CHAR_SPACE}) begin
            seq[0] = CHAR_PLUS;
         end else if (u > 16'd255) begin
            n = 6;
            seq[0] = CHAR_PERCENT;
            seq[1] = CHAR_LOWER_U;
            seq[2] = ascii_hex(u[15:12]);
            seq[3] = ascii_hex(u[11:8]);
            seq[4] = ascii_hex(u[7:4]);
            seq[5] = ascii_hex(u[3:0]);
         end else if (u > 16'd127 || is_unsafe(u[7:0])) begin
            n = 3;
            seq[0] = CHAR_PERCENT;
            seq[1] = ascii_hex(u[7:4]);
            seq[2] = ascii_hex(u[3:0]);
         end else begin
            seq[0] = u[7:0];
         end
         // room check is the same for every kind of unit
         if (emitted_count + n > capacity) begin
            overflowed = 1'b1;
         end else begin
            if (!past_question && u == {8'h00, CHAR_QUESTION}) past_question = 1'b1;
            emitted_count += n;
            for (int k = 0; k < n; k++) begin
               expected_chars.push_back(make_char(seq[k], k == n - 1, STATUS_NONE));
            end
         end
      end
   endtask

   // compare one result transfer against the oldest expectation
   task automatic check_char(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_chars.size() == 0) begin
         $display("%0t: unexpected character %h last %b status %0d",
                  $time, got.out_char, got.last, got.status);
         errors++;
      end else begin
         want = expected_chars.pop_front();
         checked++;
         if (got.out_char !== want.out_char || got.last !== want.last ||
             got.status !== want.status) begin
            $display("%0t: mismatch expected char %h last %b status %0d, got %h %b %0d",
                     $time, want.out_char, want.last, want.status,
                     got.out_char, got.last, got.status);
            errors++;
         end
      end
   endtask

   // watch both channels and the capacity port
   always @(posedge clock) begin
      if (reset) begin
         expected_chars.delete();
         capacity      = CAPACITY_RESET;
         emitted_count = 0;
         past_question = 1'b0;
         overflowed    = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_char(rsp_payload);
         if (req_valid && req_ready) predict_unit(req_payload);
         if (csr_write_en) capacity = csr_write_data;
      end
      pending_count <= expected_chars.size();
      error_count   <= errors;
      checked_count <= checked;
   end

endmodule

// ===== tb/tb_top.sv =====
// testbench top for the url query percent encoder: stimulus, result sink and verdict
module tb_top
   import urlenc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic            clock;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_en = 1'b0;
   logic [15:0]     csr_write_data = '0;

   int error_count;
   int pending_count;
   int checked_count;

   // no idling on either side while set
   logic steady = 1'b0;
   int units_sent = 0;
   int strings_sent = 0;
   int capacity_writes = 0;

   url_query_percent_encoder_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   url_encode_checker watch (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // result sink with random stalls per transfer
   initial begin : result_sink
      int stall;
      forever begin
         stall = steady ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // one input transfer after a random gap
   task automatic send_unit(input logic [15:0] unit, input logic fin);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload.code_unit     <= unit;
      req_payload.end_of_string <= fin;
      do @(posedge clock); while (!req_ready);
      units_sent++;
      if (fin) strings_sent++;
   endtask

   task automatic end_string();
      send_unit(16'($urandom), 1'b1);
   endtask

   // hold the sender until every expected character has come out
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      capacity_writes++;
   endtask

   function automatic logic [7:0] pick_unsafe();
      case ($urandom_range(0, 12))
         0:       return CHAR_QUOTE;
         1:       return CHAR_LT;
         2:       return CHAR_GT;
         3:       return CHAR_HASH;
         4:       return CHAR_LBRACE;
         5:       return CHAR_RBRACE;
         6:       return CHAR_PIPE;
         7:       return CHAR_BSLASH;
         8:       return CHAR_CARET;
         9:       return CHAR_TILDE;
         10:      return CHAR_LBRACKET;
         11:      return CHAR_RBRACKET;
         default: return CHAR_BACKTICK;
      endcase
   endfunction

   // code unit spread over every encoding class
   function automatic logic [15:0] pick_unit();
      case ($urandom_range(0, 9))
         0:       return {8'h00, CHAR_SPACE};
         1:       return {8'h00, pick_unsafe()};
         2:       return 16'($urandom_range(128, 255));
         3:       return 16'($urandom_range(256, 65535));
         4:       return 16'($urandom);
         5:       return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
         default: return 16'($urandom_range(16'h21, 16'h7E));
      endcase
   endfunction

   // mostly roomy, sometimes tight enough to truncate
   function automatic logic [15:0] pick_capacity();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1, 2:    return 16'hFFFF;
         3, 4:    return 16'($urandom_range(1, 12));
         5:       return 16'($urandom_range(13, 60));
         default: return 16'($urandom_range(61, 65535));
      endcase
   endfunction

   initial begin : stimulus
      int len;
      int qpos;
      int cut;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // wide and zero units before the question mark, every class of unit after it
      write_capacity(16'hFFFF);
      send_unit(16'hFFFF, 1'b0);
      send_unit(16'h0000, 1'b0);
      send_unit({8'h00, CHAR_QUESTION}, 1'b0);
      send_unit({8'h00, CHAR_SPACE}, 1'b0);
      send_unit({8'h00, CHAR_QUOTE}, 1'b0);
      send_unit({8'h00, CHAR_TILDE}, 1'b0);
      send_unit({8'h00, CHAR_BACKTICK}, 1'b0);
      send_unit(16'h0080, 1'b0);
      send_unit(16'h00FF, 1'b0);
      send_unit(16'h0100, 1'b0);
      send_unit(16'hFFFF, 1'b0);
      send_unit(16'h0000, 1'b0);
      send_unit({8'h00, CHAR_QUESTION}, 1'b0);
      end_string();

      // question mark that does not fit
      drain();
      write_capacity(16'd1);
      send_unit(16'h0061, 1'b0);
      send_unit({8'h00, CHAR_QUESTION}, 1'b0);
      end_string();

      // zero capacity: empty string completes, any unit truncates
      drain();
      write_capacity(16'd0);
      end_string();
      send_unit(16'h0061, 1'b0);
      end_string();

      // percent-u expansion filling the capacity exactly
      drain();
      write_capacity(16'd7);
      send_unit({8'h00, CHAR_QUESTION}, 1'b0);
      send_unit(16'h1234, 1'b0);
      send_unit(16'h0078, 1'b0);
      end_string();

      // random strings, some with a capacity change in the middle
      while (units_sent < 245) begin
         steady = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 2) == 0) begin
            drain();
            write_capacity(pick_capacity());
         end
         len  = $urandom_range(0, 10);
         qpos = $urandom_range(0, len);
         cut  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : -1;
         for (int i = 0; i < len; i++) begin
            if (i == cut) begin
               drain();
               write_capacity(16'($urandom_range(0, 12)));
            end
            if (i == qpos) begin
               send_unit({8'h00, CHAR_QUESTION}, 1'b0);
            end else begin
               send_unit(pick_unit(), 1'b0);
            end
         end
         end_string();
      end

      // let every expected character arrive
      steady = 1'b0;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);

      $display("summary: %0d units in %0d strings, %0d capacity writes",
               units_sent, strings_sent, capacity_writes);
      $display("summary: %0d characters compared, %0d mismatches", checked_count,
               error_count);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/urlenc_pkg.sv
rtl/urlenc_queue.sv
rtl/urlenc_front.sv
rtl/urlenc_back.sv
rtl/url_query_percent_encoder_top.sv
tb/url_encode_checker.sv
tb/tb_top.sv
